// ===== hw/rtl/cgtp_pkg.sv =====
// Shared constants, types and helper functions of the counter goodness task picker.
package cgtp_pkg;

  // Table size and counter width.
  localparam int MAX_TASKS    = 64;
  localparam int COUNTER_BITS = 16;

  // Derived widths.
  localparam int TASK_AW = $clog2(MAX_TASKS);
  localparam int QC_W    = $clog2(MAX_TASKS + 1);
  localparam int CNT_W   = COUNTER_BITS;

  // Fixed field widths of the request and result items.
  localparam int BASE_W  = 8;
  localparam int PRIO_W  = 7;
  localparam int ID_W    = 6;
  localparam int REQ_W   = 3;
  localparam int QLEN_W  = 7;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = BASE_W + 1;
  localparam int SAT_W   = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  // Largest counter value, at the width used for saturation.
  localparam logic [SAT_W-1:0] CNT_CAP = SAT_W'((64'd1 << CNT_W) - 64'd1);

  // Reset value of the base time slice.
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE  = 3'd0,
    REQ_ENQUEUE = 3'd1,
    REQ_DEQUEUE = 3'd2,
    REQ_TICK    = 3'd3,
    REQ_PICK    = 3'd4
  } req_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_BAD   = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_ENQ,
    ST_DEQ,
    ST_SCAN,
    ST_REFILL
  } state_t;

  // Request item.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] priority_req;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [ID_W-1:0]   picked_task;
    logic              pick_valid;
    logic              counters_refilled;
    logic              resched_flag;
    logic [QLEN_W-1:0] queue_length;
    logic [STAT_W-1:0] status;
  } out_t;

  // One entry of the task memory.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  cnt;
  } task_ent_t;

  // Base plus priority, saturated at the largest counter value.
  function automatic logic [CNT_W-1:0] fill_value(input logic [BASE_W-1:0] base,
                                                  input logic [PRIO_W-1:0] prio);
    logic [SAT_W-1:0] sum;
    sum = SAT_W'(base) + SAT_W'(prio);
    return (sum > CNT_CAP) ? CNT_W'(CNT_CAP) : CNT_W'(sum);
  endfunction

endpackage

// ===== hw/rtl/cgtp_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
module cgtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/counter_goodness_task_picker.sv =====
// Top level of the counter goodness task picker: request sequencer around two RAMs.
//
//   channel   ports                              transfer when
//   --------  ---------------------------------  ---------------------------
//   request   start, busy, in_data               start high and busy low
//   result    out_valid, out_data                out_valid high (one cycle)
//   config    cfg_valid, cfg_ready, cfg_data     cfg_valid and cfg_ready high
//
// Rejected requests, create and a pick on an empty queue are answered from idle; a tick reads
// the counter and then writes it back. Enqueue and dequeue shift the queue one slot a cycle
// (an enqueue to an empty queue writes the head directly). A pick scans the queue; on a zero
// best it runs a refill sweep over all MAX_TASKS entries and then a second scan. Synchronous
// reset clears the existence and queued bits and the queue count and loads the base time
// slice; the memories need no clearing pass. The receiver cannot stall: the next request may
// transfer in the result cycle.
module counter_goodness_task_picker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  cgtp_pkg::in_t                in_data,
  output logic                         out_valid,
  output cgtp_pkg::out_t               out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cgtp_pkg::BASE_W-1:0]  cfg_data
);

  import cgtp_pkg::*;

  localparam int TENT_W = $bits(task_ent_t);

  // Control registers.
  state_t               state_r, state_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic [MAX_TASKS-1:0] exists_r, exists_nxt;
  logic [MAX_TASKS-1:0] queued_r, queued_nxt;
  logic [QC_W-1:0]      qcount_r, qcount_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 issue_done_r, issue_done_nxt;
  logic                 s1_v_r, s1_v_nxt;
  logic                 s2_v_r, s2_v_nxt;
  logic                 found_r, found_nxt;
  logic                 have_best_r, have_best_nxt;
  logic                 refilled_r, refilled_nxt;

  // Payload registers.
  in_t                  req_r, req_nxt;
  out_t                 out_r, out_nxt;
  logic [TASK_AW-1:0]   idx_r, idx_nxt;
  logic [TASK_AW-1:0]   s1_addr_r, s1_addr_nxt;
  logic [TASK_AW-1:0]   s2_id_r, s2_id_nxt;
  logic [TASK_AW-1:0]   best_id_r, best_id_nxt;
  logic [CNT_W-1:0]     best_cnt_r, best_cnt_nxt;

  // Memory ports.
  logic                 t_we;
  logic [TASK_AW-1:0]   t_waddr, t_raddr;
  task_ent_t            t_wdata;
  logic [TENT_W-1:0]    t_rdata;
  task_ent_t            t_rd_ent;
  logic                 q_we;
  logic [TASK_AW-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;

  // Request decode.
  logic                 accept;
  logic                 id_ok;
  logic [TASK_AW-1:0]   tid;
  logic [TASK_AW-1:0]   req_tid;
  logic [TASK_AW-1:0]   q_last;
  out_t                 res;

  // Task memory: priority and counter per task.
  cgtp_ram #(
    .WIDTH (TENT_W),
    .DEPTH (MAX_TASKS)
  ) u_task_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // Queue memory: task ids, newest at slot zero.
  cgtp_ram #(
    .WIDTH (TASK_AW),
    .DEPTH (MAX_TASKS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign t_rd_ent  = task_ent_t'(t_rdata);
  assign accept    = start && (state_r == ST_IDLE);
  assign id_ok     = (32'(in_data.task_id) < 32'(MAX_TASKS));
  assign tid       = TASK_AW'(in_data.task_id);
  assign req_tid   = TASK_AW'(req_r.task_id);
  assign q_last    = TASK_AW'(qcount_r - QC_W'(1));

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Sequencer: next state, memory accesses and the result.
  always_comb begin
    state_nxt      = state_r;
    base_nxt       = cfg_valid ? cfg_data : base_r;
    exists_nxt     = exists_r;
    queued_nxt     = queued_r;
    qcount_nxt     = qcount_r;
    out_valid_nxt  = 1'b0;
    issue_done_nxt = issue_done_r;
    s1_v_nxt       = s1_v_r;
    s2_v_nxt       = s2_v_r;
    found_nxt      = found_r;
    have_best_nxt  = have_best_r;
    refilled_nxt   = refilled_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    s1_addr_nxt    = s1_addr_r;
    s2_id_nxt      = s2_id_r;
    best_id_nxt    = best_id_r;
    best_cnt_nxt   = best_cnt_r;

    t_we     = 1'b0;
    t_waddr  = '0;
    t_wdata  = '0;
    t_raddr  = '0;
    q_we     = 1'b0;
    q_waddr  = '0;
    q_wdata  = '0;
    q_raddr  = '0;

    res        = '0;
    res.status = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        t_raddr = tid;
        if (accept) begin
          req_nxt        = in_data;
          idx_nxt        = '0;
          issue_done_nxt = 1'b0;
          s1_v_nxt       = 1'b0;
          s2_v_nxt       = 1'b0;
          case (in_data.req_type)
            REQ_CREATE: begin
              out_valid_nxt = 1'b1;
              if (!id_ok || exists_r[tid]) begin
                res.status = STAT_BAD;
              end else begin
                exists_nxt[tid] = 1'b1;
                t_we            = 1'b1;
                t_waddr         = tid;
                t_wdata.prio    = in_data.priority_req;
                t_wdata.cnt     = fill_value(base_r, in_data.priority_req);
              end
            end
            REQ_ENQUEUE: begin
              if (!id_ok || !exists_r[tid] || queued_r[tid] ||
                  (32'(qcount_r) >= 32'(MAX_TASKS))) begin
                out_valid_nxt = 1'b1;
                res.status    = STAT_BAD;
              end else if (qcount_r == '0) begin
                // Empty queue: the new task goes straight to the head.
                q_we            = 1'b1;
                q_waddr         = '0;
                q_wdata         = tid;
                queued_nxt[tid] = 1'b1;
                qcount_nxt      = qcount_r + QC_W'(1);
                out_valid_nxt   = 1'b1;
              end else begin
                idx_nxt   = q_last;
                state_nxt = ST_ENQ;
              end
            end
            REQ_DEQUEUE: begin
              if (!id_ok || !queued_r[tid]) begin
                out_valid_nxt = 1'b1;
                res.status    = STAT_BAD;
              end else begin
                found_nxt = 1'b0;
                state_nxt = ST_DEQ;
              end
            end
            REQ_TICK: begin
              if (!id_ok || !exists_r[tid]) begin
                out_valid_nxt = 1'b1;
                res.status    = STAT_BAD;
              end else begin
                state_nxt = ST_TICK;
              end
            end
            REQ_PICK: begin
              if (qcount_r == '0) begin
                out_valid_nxt = 1'b1;
                res.status    = STAT_EMPTY;
              end else begin
                have_best_nxt = 1'b0;
                refilled_nxt  = 1'b0;
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              res.status    = STAT_BAD;
            end
          endcase
        end
      end

      ST_TICK: begin
        // Write back the decremented counter, clamped at zero.
        t_we         = 1'b1;
        t_waddr      = req_tid;
        t_wdata.prio = t_rd_ent.prio;
        if (t_rd_ent.cnt <= CNT_W'(1)) begin
          t_wdata.cnt      = '0;
          res.resched_flag = 1'b1;
        end else begin
          t_wdata.cnt = t_rd_ent.cnt - CNT_W'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_ENQ: begin
        // Move each slot up by one, from the tail down, then write the head.
        if (s1_v_r) begin
          q_we    = 1'b1;
          q_waddr = s1_addr_r + TASK_AW'(1);
          q_wdata = q_rdata;
        end
        if (!issue_done_r) begin
          q_raddr     = idx_r;
          s1_v_nxt    = 1'b1;
          s1_addr_nxt = idx_r;
          if (idx_r == '0) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r - TASK_AW'(1);
          end
        end else begin
          s1_v_nxt = 1'b0;
          if (!s1_v_r) begin
            q_we                = 1'b1;
            q_waddr             = '0;
            q_wdata             = req_tid;
            queued_nxt[req_tid] = 1'b1;
            qcount_nxt          = qcount_r + QC_W'(1);
            out_valid_nxt       = 1'b1;
            state_nxt           = ST_IDLE;
          end
        end
      end

      ST_DEQ: begin
        // Walk the queue from the head; every slot after the match moves down.
        if (s1_v_r) begin
          if (found_r) begin
            q_we    = 1'b1;
            q_waddr = s1_addr_r - TASK_AW'(1);
            q_wdata = q_rdata;
          end
          if (q_rdata == req_tid) begin
            found_nxt = 1'b1;
          end
        end
        if (!issue_done_r) begin
          q_raddr     = idx_r;
          s1_v_nxt    = 1'b1;
          s1_addr_nxt = idx_r;
          if (idx_r == q_last) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + TASK_AW'(1);
          end
        end else begin
          s1_v_nxt = 1'b0;
          if (!s1_v_r) begin
            queued_nxt[req_tid] = 1'b0;
            qcount_nxt          = qcount_r - QC_W'(1);
            out_valid_nxt       = 1'b1;
            state_nxt           = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        // Compare stage: a strictly larger counter wins, so the newest keeps a tie.
        if (s2_v_r) begin
          if (!have_best_r || (t_rd_ent.cnt > best_cnt_r)) begin
            best_cnt_nxt  = t_rd_ent.cnt;
            best_id_nxt   = s2_id_r;
            have_best_nxt = 1'b1;
          end
        end
        // Task memory read stage.
        s2_v_nxt = s1_v_r;
        if (s1_v_r) begin
          t_raddr   = q_rdata;
          s2_id_nxt = q_rdata;
        end
        // Queue memory read stage.
        if (!issue_done_r) begin
          q_raddr  = idx_r;
          s1_v_nxt = 1'b1;
          if (idx_r == q_last) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + TASK_AW'(1);
          end
        end else begin
          s1_v_nxt = 1'b0;
        end
        // Pipeline drained: refill once on a zero best, otherwise report.
        if (issue_done_r && !s1_v_r && !s2_v_r) begin
          if ((best_cnt_r == '0) && !refilled_r) begin
            idx_nxt        = '0;
            issue_done_nxt = 1'b0;
            s1_v_nxt       = 1'b0;
            state_nxt      = ST_REFILL;
          end else begin
            res.picked_task       = ID_W'(best_id_r);
            res.pick_valid        = 1'b1;
            res.counters_refilled = refilled_r;
            out_valid_nxt         = 1'b1;
            state_nxt             = ST_IDLE;
          end
        end
      end

      ST_REFILL: begin
        // Sweep every task; existing ones get base plus priority.
        if (s1_v_r && exists_r[s1_addr_r]) begin
          t_we         = 1'b1;
          t_waddr      = s1_addr_r;
          t_wdata.prio = t_rd_ent.prio;
          t_wdata.cnt  = fill_value(base_r, t_rd_ent.prio);
        end
        if (!issue_done_r) begin
          t_raddr     = idx_r;
          s1_v_nxt    = 1'b1;
          s1_addr_nxt = idx_r;
          if (idx_r == TASK_AW'(MAX_TASKS - 1)) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + TASK_AW'(1);
          end
        end else begin
          s1_v_nxt = 1'b0;
          if (!s1_v_r) begin
            idx_nxt        = '0;
            issue_done_nxt = 1'b0;
            s2_v_nxt       = 1'b0;
            have_best_nxt  = 1'b0;
            refilled_nxt   = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.queue_length = QLEN_W'(qcount_nxt);
    out_nxt          = res;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_r       <= BASE_RESET;
      exists_r     <= '0;
      queued_r     <= '0;
      qcount_r     <= '0;
      out_valid_r  <= 1'b0;
      issue_done_r <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      found_r      <= 1'b0;
      have_best_r  <= 1'b0;
      refilled_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      exists_r     <= exists_nxt;
      queued_r     <= queued_nxt;
      qcount_r     <= qcount_nxt;
      out_valid_r  <= out_valid_nxt;
      issue_done_r <= issue_done_nxt;
      s1_v_r       <= s1_v_nxt;
      s2_v_r       <= s2_v_nxt;
      found_r      <= found_nxt;
      have_best_r  <= have_best_nxt;
      refilled_r   <= refilled_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_r      <= out_nxt;
    idx_r      <= idx_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s2_id_r    <= s2_id_nxt;
    best_id_r  <= best_id_nxt;
    best_cnt_r <= best_cnt_nxt;
  end

`ifndef NO_ASSERTIONS
  // The queue count always matches the number of queued tasks.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == 32'(qcount_r))
    else $error("queue count differs from queued bits");

  // Only existing tasks can be queued.
  a_queued_exist: assert property (@(posedge clk) disable iff (!rst_n)
    (queued_r & ~exists_r) == '0)
    else $error("queued task does not exist");

  // A chosen task always comes with an ok status.
  a_pick_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.pick_valid) |-> (out_r.status == STAT_OK))
    else $error("pick result with bad status");

  // A refill is only reported together with a chosen task.
  a_refill_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.counters_refilled) |-> out_r.pick_valid)
    else $error("refill reported without a pick");

  // A result ends every sequenced request on its way back to idle.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && (state_nxt == ST_IDLE)) |=> out_valid_r)
    else $error("request finished without a result");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the counter goodness task picker.
module tb_top;
  import cgtp_pkg::*;

  // Request codes outside the defined set; the block must reject them.
  localparam logic [REQ_W-1:0] REQ_BOGUS_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BOGUS_LAST  = 3'd7;

  localparam int SLICE_MAX   = (1 << CNT_W) - 1;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_WAIT  = 250;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_t                 in_data;
  logic                out_valid;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BASE_W-1:0]   cfg_data;

  // Scheduler state as the testbench predicts it.
  logic [BASE_W-1:0]   base_slice;
  logic                task_live [MAX_TASKS];
  logic                on_runq [MAX_TASKS];
  logic [PRIO_W-1:0]   task_prio [MAX_TASKS];
  logic [CNT_W-1:0]    slice_left [MAX_TASKS];
  logic [ID_W-1:0]     run_q [$];
  out_t                pending_results [$];

  int                  running_task;
  int                  idle_pct;
  int                  mismatches;
  int                  n_requests;
  int                  n_checked;
  int                  n_picks;
  int                  n_refills;
  int                  n_resched;
  int                  deepest_q;
  int unsigned         cycles_run;

  counter_goodness_task_picker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Time slice given to a task on create and on refill, saturated at the counter width.
  function automatic logic [CNT_W-1:0] refill_slice(input logic [PRIO_W-1:0] prio);
    int s;
    s = int'(base_slice) + int'(prio);
    return (s > SLICE_MAX) ? CNT_W'(SLICE_MAX) : CNT_W'(s);
  endfunction

  // Run-queue position with the most slice left; the newest entry wins a tie.
  function automatic int best_slot();
    int b;
    b = 0;
    for (int i = 1; i < run_q.size(); i++)
      if (slice_left[run_q[i]] > slice_left[run_q[b]]) b = i;
    return b;
  endfunction

  // Applies one request to the predicted state and returns the result it should give.
  function automatic out_t sched_predict(input in_t rq);
    out_t r;
    int   id;
    int   slot;
    r = '0;
    r.status = STAT_OK;
    id = rq.task_id;
    case (rq.req_type)
      REQ_CREATE: begin
        if (task_live[id]) begin
          r.status = STAT_BAD;
        end else begin
          task_live[id] = 1'b1;
          task_prio[id] = rq.priority_req;
          slice_left[id] = refill_slice(rq.priority_req);
        end
      end
      REQ_ENQUEUE: begin
        if (!task_live[id] || on_runq[id] || run_q.size() >= MAX_TASKS) begin
          r.status = STAT_BAD;
        end else begin
          run_q.push_front(ID_W'(id));
          on_runq[id] = 1'b1;
        end
      end
      REQ_DEQUEUE: begin
        if (!on_runq[id]) begin
          r.status = STAT_BAD;
        end else begin
          for (int i = 0; i < run_q.size(); i++)
            if (run_q[i] == id) begin
              run_q.delete(i);
              break;
            end
          on_runq[id] = 1'b0;
        end
      end
      REQ_TICK: begin
        if (!task_live[id]) begin
          r.status = STAT_BAD;
        end else if (slice_left[id] <= 1) begin
          slice_left[id] = '0;
          r.resched_flag = 1'b1;
        end else begin
          slice_left[id] = slice_left[id] - 1'b1;
        end
      end
      REQ_PICK: begin
        if (run_q.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          slot = best_slot();
          // Every queued slice is used up: refill all tasks and scan again.
          if (slice_left[run_q[slot]] == 0) begin
            for (int i = 0; i < MAX_TASKS; i++)
              if (task_live[i]) slice_left[i] = refill_slice(task_prio[i]);
            r.counters_refilled = 1'b1;
            slot = best_slot();
          end
          r.picked_task = run_q[slot];
          r.pick_valid = 1'b1;
        end
      end
      default: begin
        r.status = STAT_BAD;
      end
    endcase
    r.queue_length = QLEN_W'(run_q.size());
    return r;
  endfunction

  // A task that the request can legally act on, or -1 when there is none.
  function automatic int target_for(input logic [REQ_W-1:0] op);
    int c [$];
    if (op == REQ_TICK && running_task >= 0 && $urandom_range(99) < 65) return running_task;
    for (int i = 0; i < MAX_TASKS; i++)
      case (op)
        REQ_CREATE:  if (!task_live[i]) c.push_back(i);
        REQ_ENQUEUE: if (task_live[i] && !on_runq[i]) c.push_back(i);
        REQ_DEQUEUE: if (on_runq[i]) c.push_back(i);
        REQ_TICK:    if (task_live[i]) c.push_back(i);
        default: ;
      endcase
    return (c.size() == 0) ? -1 : c[$urandom_range(c.size() - 1)];
  endfunction

  // Presents one request, waits for its transfer, then idles at random.
  task automatic send_req(input logic [REQ_W-1:0] op, input int id,
                          input logic [PRIO_W-1:0] prio);
    in_t  rq;
    out_t want;
    int   gap;
    rq.req_type = op;
    rq.task_id = ID_W'(id);
    rq.priority_req = prio;
    start <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (busy);
    want = sched_predict(rq);
    if (want.pick_valid) running_task = want.picked_task;
    pending_results.push_back(want);
    n_requests++;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic end_burst();
    start <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes the base time slice while the block is idle.
  task automatic set_base(input logic [BASE_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_slice = v;
  endtask

  // Rejections, field extremes, the reset base, refill and the all-zero refill.
  task automatic test_directed();
    idle_pct = 0;
    send_req(REQ_PICK, 0, '0);
    send_req(REQ_TICK, 5, '0);
    send_req(REQ_ENQUEUE, 5, '0);
    send_req(REQ_DEQUEUE, 5, '0);
    send_req(REQ_BOGUS_FIRST, 63, 7'h7f);
    send_req(REQ_BOGUS_FIRST + 3'd1, 21, 7'h2a);
    send_req(REQ_BOGUS_LAST, 42, 7'h55);
    send_req(REQ_CREATE, 63, 7'h7f);
    send_req(REQ_CREATE, 63, 7'h00);
    end_burst();
    set_base('0);
    send_req(REQ_CREATE, 0, 7'd0);
    send_req(REQ_CREATE, 1, 7'd1);
    send_req(REQ_ENQUEUE, 0, '0);
    send_req(REQ_ENQUEUE, 1, '0);
    send_req(REQ_ENQUEUE, 1, '0);
    // Run task 1 dry, then past zero.
    send_req(REQ_TICK, 1, '0);
    send_req(REQ_TICK, 1, '0);
    send_req(REQ_PICK, 33, '0);
    send_req(REQ_TICK, 1, '0);
    // Only zero-priority tasks queued: the refill leaves all at zero and the head wins.
    send_req(REQ_DEQUEUE, 1, '0);
    send_req(REQ_PICK, 12, '0);
    send_req(REQ_CREATE, 2, 7'd0);
    send_req(REQ_ENQUEUE, 2, '0);
    send_req(REQ_PICK, 45, '0);
    end_burst();
  endtask

  // Fills the run queue to every task, picks over it, then drains most of it.
  task automatic test_full_queue();
    int id;
    idle_pct = 12;
    for (id = target_for(REQ_CREATE); id >= 0; id = target_for(REQ_CREATE))
      send_req(REQ_CREATE, id, PRIO_W'($urandom_range(15)));
    for (id = target_for(REQ_ENQUEUE); id >= 0; id = target_for(REQ_ENQUEUE))
      send_req(REQ_ENQUEUE, id, PRIO_W'($urandom));
    send_req(REQ_PICK, $urandom_range(MAX_TASKS - 1), PRIO_W'($urandom));
    send_req(REQ_PICK, $urandom_range(MAX_TASKS - 1), PRIO_W'($urandom));
    send_req(REQ_ENQUEUE, $urandom_range(MAX_TASKS - 1), PRIO_W'($urandom));
    while (run_q.size() > 8)
      send_req(REQ_DEQUEUE, target_for(REQ_DEQUEUE), PRIO_W'($urandom));
    end_burst();
  endtask

  // Scheduling traffic: slices picked and ticked down, queue churn, some noise.
  task automatic test_time_slices(input int n_items, input logic [BASE_W-1:0] base,
                                  input int idle);
    int                r;
    int                id;
    logic [REQ_W-1:0]  op;
    logic [PRIO_W-1:0] prio;
    set_base(base);
    idle_pct = idle;
    repeat (n_items) begin
      r = $urandom_range(99);
      if (r < 5) op = REQ_CREATE;
      else if (r < 25) op = (run_q.size() < 16) ? REQ_ENQUEUE : REQ_DEQUEUE;
      else if (r < 37) op = REQ_DEQUEUE;
      else if (r < 67) op = REQ_TICK;
      else if (r < 95) op = REQ_PICK;
      else op = REQ_W'($urandom_range(REQ_BOGUS_LAST, REQ_BOGUS_FIRST));
      id = target_for(op);
      if (id < 0 || $urandom_range(99) < 8) id = $urandom_range(MAX_TASKS - 1);
      prio = ($urandom_range(3) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(7));
      send_req(op, id, prio);
    end
    end_burst();
  endtask

  // Compares one result field and counts a mismatch.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("Result transfer with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("picked_task", want.picked_task, out_data.picked_task);
        check_field("pick_valid", want.pick_valid, out_data.pick_valid);
        check_field("counters_refilled", want.counters_refilled, out_data.counters_refilled);
        check_field("resched_flag", want.resched_flag, out_data.resched_flag);
        check_field("queue_length", want.queue_length, out_data.queue_length);
        check_field("status", want.status, out_data.status);
        n_checked++;
        if (want.pick_valid) n_picks++;
        if (want.counters_refilled) n_refills++;
        if (want.resched_flag) n_resched++;
        if (want.queue_length > deepest_q) deepest_q = want.queue_length;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    base_slice = BASE_RESET;
    running_task = -1;
    idle_pct = 0;
    mismatches = 0;
    n_requests = 0;
    n_checked = 0;
    n_picks = 0;
    n_refills = 0;
    n_resched = 0;
    deepest_q = 0;
    cycles_run = 0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      task_live[i] = 1'b0;
      on_runq[i] = 1'b0;
      task_prio[i] = '0;
      slice_left[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_time_slices(350, 8'd3, 0);
    test_full_queue();
    test_time_slices(330, 8'd0, 78);
    test_time_slices(200, 8'd255, 12);
    test_time_slices(270, BASE_W'($urandom_range(254, 1)), 78);

    // Let the last result arrive, then watch for stray transfers.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests over six base slice settings, checked %0d results.",
             n_requests, n_checked);
    $display("Picks %0d, refills %0d, reschedules %0d, run queue up to %0d tasks.",
             n_picks, n_refills, n_resched, deepest_q);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
